[design/assert_macros.svh]
// Assertion macros shared by the remap compactor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[design/cvrc_pkg.sv]
// Shared types and constants for the chunk vertex remap compactor
package cvrc_pkg;

  // Remap table depth and address width
  localparam int VERTEX_SLOTS = 65536;
  localparam int ADDR_W       = $clog2(VERTEX_SLOTS);

  // Field widths
  localparam int SRC_W   = 16;
  localparam int LOCAL_W = 16;
  localparam int CNT_W   = 17;

  // Generation tag; tag zero marks an empty entry and is never current
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_EMPTY = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Input item kinds
  localparam logic KIND_CORNER = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // One remap table entry
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [LOCAL_W-1:0] local_idx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Status from the generation/clear controller to the datapath
  typedef struct packed {
    logic               busy;        // clearing pass running
    logic               last_epoch;  // next end of chunk starts a clearing pass
    logic [EPOCH_W-1:0] epoch;
    logic [ADDR_W-1:0]  sweep_addr;
  } gen_status_t;

endpackage

[design/chunk_vertex_remap_compactor.sv]
// Chunk vertex remap compactor: top level with lookup/update pipeline
// Takes one item per cycle while the output is not stalled and no clearing pass
// runs or is about to start, and returns its result through the read of the
// remap RAM, then the update and output register; the rate is set by the RAM's
// one read and one write port, with the last written entry forwarded to the next
// lookup. The remap table holds a generation tag per entry, so an end-of-chunk
// item retires the chunk by advancing the tag. After reset, and after every 255th
// end-of-chunk item, a clearing pass rewrites all VERTEX_SLOTS (65536) entries of
// the table while in_ready is low. A configuration write applies to the item in
// the lookup stage, so write the register only while no item is in flight.
module chunk_vertex_remap_compactor (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [cvrc_pkg::CNT_W-1:0]  cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [cvrc_pkg::SRC_W-1:0]  source_index,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cvrc_pkg::LOCAL_W-1:0] local_index,
  output logic                        new_vertex,
  output logic                        out_of_range,
  output logic                        chunk_done,
  output logic [cvrc_pkg::CNT_W-1:0]  chunk_vertices
);
  import cvrc_pkg::*;

  `include "assert_macros.svh"

  logic [CNT_W-1:0]  vertex_count;
  logic [CNT_W-1:0]  chunk_cnt;
  gen_status_t       gen;

  // lookup stage
  logic              s1_valid;
  logic              s1_kind;
  logic [SRC_W-1:0]  s1_src;
  logic              s1_go;
  logic              in_fire;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  // last write, forwarded to a lookup that read alongside it
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  entry_t            fwd_data;

  // lookup decode
  logic [ADDR_W-1:0] s1_addr;
  entry_t            cur_entry;
  logic              s1_in_range;
  logic              s1_hit;
  logic              s1_new;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // Handshake: stall behind a full output, and hold off during a clearing pass
  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !gen.busy &&
                    (!s1_valid || (s1_go && !(s1_kind == KIND_END && gen.last_epoch)));
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind <= kind;
      s1_src  <= source_index;
    end
  end

  // Lookup decode
  always_comb begin
    s1_addr     = ADDR_W'(s1_src);
    cur_entry   = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
    s1_in_range = ({1'b0, s1_src} < vertex_count) && (32'(s1_src) < VERTEX_SLOTS);
    s1_hit      = (cur_entry.epoch == gen.epoch);
    s1_new      = (s1_kind == KIND_CORNER) && s1_in_range && !s1_hit;
  end

  // Table write: clearing pass, or a first-seen vertex
  always_comb begin
    if (gen.busy) begin
      ram_we              = 1'b1;
      ram_waddr           = gen.sweep_addr;
      ram_wdata.epoch     = EPOCH_EMPTY;
      ram_wdata.local_idx = '0;
    end else begin
      ram_we              = s1_go && s1_new;
      ram_waddr           = s1_addr;
      ram_wdata.epoch     = gen.epoch;
      ram_wdata.local_idx = chunk_cnt[LOCAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (gen.busy) begin
      fwd_valid <= 1'b0;
    end else if (ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  cvrc_ram #(
    .DEPTH (VERTEX_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_remap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (ADDR_W'(source_index)),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  cvrc_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .chunk_end (s1_go && s1_kind == KIND_END),
    .status    (gen)
  );

  // Distinct vertex counter of the open chunk
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_cnt <= '0;
    end else if (s1_go) begin
      if (s1_kind == KIND_END) begin
        chunk_cnt <= '0;
      end else if (s1_new) begin
        chunk_cnt <= chunk_cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      if (s1_kind == KIND_END) begin
        local_index    <= '0;
        new_vertex     <= 1'b0;
        out_of_range   <= 1'b0;
        chunk_done     <= 1'b1;
        chunk_vertices <= chunk_cnt;
      end else if (!s1_in_range) begin
        local_index    <= '0;
        new_vertex     <= 1'b0;
        out_of_range   <= 1'b1;
        chunk_done     <= 1'b0;
        chunk_vertices <= '0;
      end else if (s1_hit) begin
        local_index    <= cur_entry.local_idx;
        new_vertex     <= 1'b0;
        out_of_range   <= 1'b0;
        chunk_done     <= 1'b0;
        chunk_vertices <= '0;
      end else begin
        local_index    <= chunk_cnt[LOCAL_W-1:0];
        new_vertex     <= 1'b1;
        out_of_range   <= 1'b0;
        chunk_done     <= 1'b0;
        chunk_vertices <= '0;
      end
    end
  end

  `ASSERT_ALWAYS(a_no_take_in_sweep, !(in_ready && gen.busy), "input taken during clear")
  `ASSERT_IMPLY(a_done_alone, out_valid && chunk_done, !new_vertex && !out_of_range, "done flags")
  `ASSERT_IMPLY(a_write_source, ram_we && !gen.busy, s1_go && s1_new, "write without new vertex")
  `ASSERT_IMPLY(a_new_counts, s1_go && s1_new, chunk_cnt < CNT_W'(VERTEX_SLOTS), "count overflow")

endmodule

[design/cvrc_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port
module cvrc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/cvrc_gen.sv]
// Generation tag counter and clearing-pass sequencer for the remap table
module cvrc_gen (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 chunk_end,
  output cvrc_pkg::gen_status_t status
);
  import cvrc_pkg::*;

  `include "assert_macros.svh"

  logic [EPOCH_W-1:0] epoch;
  logic               busy;
  logic [ADDR_W-1:0]  sweep_addr;

  // Tag advances per chunk; a wrap restarts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= EPOCH_FIRST;
      busy       <= 1'b1;
      sweep_addr <= '0;
    end else if (busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == ADDR_W'(VERTEX_SLOTS - 1)) begin
        busy <= 1'b0;
      end
    end else if (chunk_end) begin
      if (epoch == EPOCH_LAST) begin
        epoch      <= EPOCH_FIRST;
        busy       <= 1'b1;
        sweep_addr <= '0;
      end else begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  always_comb begin
    status.busy       = busy;
    status.last_epoch = (epoch == EPOCH_LAST);
    status.epoch      = epoch;
    status.sweep_addr = sweep_addr;
  end

  `ASSERT_ALWAYS(a_epoch_live, epoch != EPOCH_EMPTY, "current tag is the empty tag")
  `ASSERT_IMPLY(a_sweep_step, !$past(rst) && busy && $past(busy), sweep_addr == ADDR_W'($past(sweep_addr) + 1'b1), "clearing pass skipped an entry")
  `ASSERT_IMPLY(a_no_end_in_sweep, busy, !chunk_end, "end of chunk during clearing pass")

endmodule
